// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl files that check their own behavior
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_SYNC(label, clk, rst, !(cond), msg)

`endif

// ----- hw/rtl/ops_pkg.sv -----
// types and constants of the output pattern sequencer
package ops_pkg;

   localparam int OP_W    = 3;
   localparam int ADDR_W  = 6;
   localparam int CHAR_W  = 8;
   localparam int REF_W   = 16;
   localparam int SHIFT_W = 4;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_START  = 3'd1,
      OP_SET    = 3'd2,
      OP_TOGGLE = 3'd3,
      OP_LOAD   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      PIN_HOLD,
      PIN_LEVEL,
      PIN_TOGGLE,
      PIN_HIGH,
      PIN_LOW
   } pin_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH_LEAD,
      ST_LEAD,
      ST_FETCH_DIGIT,
      ST_DIGIT,
      ST_ARM,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       cap_start;
      logic       write_mem;
      pin_op_type pin_op;
      logic       scan_from_read;
      logic       scan_inc;
      logic       shift_load;
      logic       read_commit;
      logic       read_rewind;
      logic       remain_dec;
      logic       remain_clear;
      logic       remain_arm;
      logic       active_set;
      logic       active_clear;
   } dp_cmd_type;

   typedef struct packed {
      logic is_end;
      logic is_space;
      logic is_plus;
      logic is_minus;
      logic is_digit;
      logic remain_le1;
      logic repeat_mode;
      logic active;
      logic pin;
   } dp_status_type;

endpackage

// ----- hw/rtl/ops_if.sv -----
// valid/ready channels for request and response beats
interface ops_req_if import ops_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic              level;
   logic [ADDR_W-1:0] address;
   logic [CHAR_W-1:0] char_code;
   logic [REF_W-1:0]  reference_ticks;
   logic              repeat_flag;

   modport source (output valid, op, level, address, char_code, reference_ticks,
      repeat_flag, input ready);
   modport sink (input valid, op, level, address, char_code, reference_ticks,
      repeat_flag, output ready);
endinterface

interface ops_rsp_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic running;

   modport source (output valid, pin_level, running, input ready);
   modport sink (input valid, pin_level, running, output ready);
endinterface

// ----- hw/rtl/ops_dp.sv -----
// datapath: pattern store, pointers, interval timer and pin register
module ops_dp import ops_pkg::*; #(
   parameter int PATTERN_DEPTH = 64,
   parameter int TICK_WIDTH    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic                level,
   input  logic [ADDR_W-1:0]   address,
   input  logic [CHAR_W-1:0]   char_code,
   input  logic [REF_W-1:0]    reference_ticks,
   input  logic                repeat_flag,
   output dp_status_type       status
);

   localparam int AW  = $clog2(PATTERN_DEPTH);
   localparam int CW  = $clog2(PATTERN_DEPTH + 1);
   localparam int PW  = (CW > ADDR_W) ? CW : ADDR_W;

   logic [CHAR_W-1:0]     mem [PATTERN_DEPTH];
   logic [CHAR_W-1:0]     rd_ff;

   logic [PW-1:0]         start_ff, start_in;
   logic [PW-1:0]         read_ff, read_in;
   logic [PW-1:0]         scan_ff, scan_in;
   logic [SHIFT_W-1:0]    shift_ff, shift_in;
   logic [TICK_WIDTH-1:0] remain_ff, remain_in;
   logic [TICK_WIDTH-1:0] period_ff, period_in;
   logic                  pin_ff, pin_in;
   logic                  active_ff, active_in;
   logic                  repeat_ff, repeat_in;

   logic [PW-1:0]         addr_ext;
   logic                  addr_ok;
   logic                  scan_ok;

   assign addr_ext = PW'(address);
   assign addr_ok  = addr_ext < PW'(PATTERN_DEPTH);
   assign scan_ok  = scan_ff < PW'(PATTERN_DEPTH);

   // pattern store, one write port for loads and one registered read at the scan pointer
   always_ff @(posedge clock) begin
      if (cmd.write_mem && addr_ok) begin
         mem[addr_ext[AW-1:0]] <= char_code;
      end
      if (scan_ok) begin
         rd_ff <= mem[scan_ff[AW-1:0]];
      end
   end

   always_comb begin
      start_in  = start_ff;
      read_in   = read_ff;
      scan_in   = scan_ff;
      shift_in  = shift_ff;
      remain_in = remain_ff;
      period_in = period_ff;
      pin_in    = pin_ff;
      active_in = active_ff;
      repeat_in = repeat_ff;

      if (cmd.cap_start) begin
         start_in  = addr_ext;
         read_in   = addr_ext;
         scan_in   = addr_ext;
         period_in = TICK_WIDTH'(reference_ticks);
         repeat_in = repeat_flag;
      end
      if (cmd.scan_from_read) begin
         scan_in = read_ff;
      end
      if (cmd.scan_inc) begin
         scan_in = scan_ff + PW'(1);
      end
      // digit characters carry their value in the low nibble
      if (cmd.shift_load) begin
         shift_in = rd_ff[SHIFT_W-1:0];
      end
      if (cmd.read_commit) begin
         read_in = scan_in;
      end
      if (cmd.read_rewind) begin
         read_in = start_ff;
      end
      if (cmd.remain_dec) begin
         remain_in = remain_ff - TICK_WIDTH'(1);
      end
      if (cmd.remain_clear) begin
         remain_in = '0;
      end
      if (cmd.remain_arm) begin
         remain_in = period_ff >> shift_ff;
      end
      if (cmd.active_set) begin
         active_in = 1'b1;
      end
      if (cmd.active_clear) begin
         active_in = 1'b0;
      end

      unique case (cmd.pin_op)
         PIN_HOLD:   pin_in = pin_ff;
         PIN_LEVEL:  pin_in = level;
         PIN_TOGGLE: pin_in = ~pin_ff;
         PIN_HIGH:   pin_in = 1'b1;
         PIN_LOW:    pin_in = 1'b0;
         default:    pin_in = pin_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         read_ff   <= '0;
         scan_ff   <= '0;
         shift_ff  <= '0;
         remain_ff <= '0;
         period_ff <= '0;
         pin_ff    <= 1'b0;
         active_ff <= 1'b0;
         repeat_ff <= 1'b0;
      end else begin
         start_ff  <= start_in;
         read_ff   <= read_in;
         scan_ff   <= scan_in;
         shift_ff  <= shift_in;
         remain_ff <= remain_in;
         period_ff <= period_in;
         pin_ff    <= pin_in;
         active_ff <= active_in;
         repeat_ff <= repeat_in;
      end
   end

   always_comb begin
      status.is_end      = !scan_ok || (rd_ff == CH_NUL);
      status.is_space    = rd_ff == CH_SPACE;
      status.is_plus     = rd_ff == CH_PLUS;
      status.is_minus    = rd_ff == CH_MINUS;
      status.is_digit    = (rd_ff >= CH_ZERO) && (rd_ff <= CH_NINE);
      status.remain_le1  = remain_ff <= TICK_WIDTH'(1);
      status.repeat_mode = repeat_ff;
      status.active      = active_ff;
      status.pin         = pin_ff;
   end

endmodule

// ----- hw/rtl/ops_ctrl.sv -----
// controller: handshakes, op decode and the token parsing sequence
module ops_ctrl import ops_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  dp_status_type   status,
   output dp_cmd_type      cmd
);

   state_type state_ff, state_in;
   op_type    op;

   assign op = op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_RESP;
               unique case (op)
                  OP_TICK: begin
                     if (status.active && status.remain_le1) begin
                        cmd.remain_clear   = 1'b1;
                        cmd.scan_from_read = 1'b1;
                        state_in           = ST_FETCH_LEAD;
                     end else if (status.active) begin
                        cmd.remain_dec = 1'b1;
                     end
                  end
                  OP_START: begin
                     cmd.cap_start    = 1'b1;
                     cmd.active_clear = 1'b1;
                     state_in         = ST_FETCH_LEAD;
                  end
                  OP_SET: begin
                     cmd.pin_op       = PIN_LEVEL;
                     cmd.active_clear = 1'b1;
                  end
                  OP_TOGGLE: begin
                     cmd.pin_op       = PIN_TOGGLE;
                     cmd.active_clear = 1'b1;
                  end
                  OP_LOAD: begin
                     cmd.write_mem = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH_LEAD: begin
            state_in = ST_LEAD;
         end
         ST_LEAD: begin
            priority if (status.is_end) begin
               cmd.read_rewind = 1'b1;
               if (status.repeat_mode) begin
                  state_in = ST_ARM;
               end else begin
                  cmd.active_clear = 1'b1;
                  state_in         = ST_RESP;
               end
            end else if (status.is_space) begin
               cmd.scan_inc = 1'b1;
               state_in     = ST_FETCH_LEAD;
            end else if (status.is_plus || status.is_minus) begin
               cmd.pin_op   = status.is_plus ? PIN_HIGH : PIN_LOW;
               cmd.scan_inc = 1'b1;
               state_in     = ST_FETCH_DIGIT;
            end else begin
               // no level mark: the same character may still be a digit
               state_in = ST_DIGIT;
            end
         end
         ST_FETCH_DIGIT: begin
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (status.is_end) begin
               cmd.read_rewind = 1'b1;
               if (status.repeat_mode) begin
                  state_in = ST_ARM;
               end else begin
                  cmd.active_clear = 1'b1;
                  state_in         = ST_RESP;
               end
            end else begin
               cmd.shift_load  = status.is_digit;
               cmd.scan_inc    = status.is_digit;
               cmd.read_commit = 1'b1;
               state_in        = ST_ARM;
            end
         end
         ST_ARM: begin
            cmd.remain_arm = 1'b1;
            cmd.active_set = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/output_pattern_sequencer_top.sv -----
// top level of the output pattern sequencer
// Drives one pin from a character pattern held in a PATTERN_DEPTH-entry store. Each
// request beat yields exactly one response beat with the pin level and the running flag.
// One beat is handled at a time. Ticks that do not end an interval, set, toggle and load
// beats offer their response the cycle after acceptance. A start beat, or a tick that
// ends an interval, parses one token from the store: the single read port delivers one
// character per fetch state, so the response waits until the leading spaces, the level
// mark and the digit have been read, longest when spaces run to the end of the store.
// A new request is accepted the cycle after the response is taken.
module output_pattern_sequencer_top import ops_pkg::*; #(
   parameter int PATTERN_DEPTH = 64,
   parameter int TICK_WIDTH    = 16
) (
   input  logic       clock,
   input  logic       reset,
   ops_req_if.sink    req_chan,
   ops_rsp_if.source  rsp_chan
);

   `include "assert_macros.svh"

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_beat;
   logic          rsp_beat;

   ops_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ops_dp #(
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .TICK_WIDTH    (TICK_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .level           (req_chan.level),
      .address         (req_chan.address),
      .char_code       (req_chan.char_code),
      .reference_ticks (req_chan.reference_ticks),
      .repeat_flag     (req_chan.repeat_flag),
      .status          (status)
   );

   assign rsp_chan.pin_level = status.pin;
   assign rsp_chan.running   = status.active;

   assign req_beat = req_chan.valid && req_chan.ready;
   assign rsp_beat = rsp_chan.valid && rsp_chan.ready;

   `ASSERT_NEVER(a_one_side_open, clock, reset, req_chan.ready && rsp_chan.valid, "both open")
   `ASSERT_SYNC(a_busy_after_accept, clock, reset, req_beat |=> !req_chan.ready, "overrun")
   `ASSERT_SYNC(a_idle_after_rsp, clock, reset, rsp_beat |=> req_chan.ready, "stuck after rsp")
   `ASSERT_NEVER(a_arm_and_stop, clock, reset, cmd.active_set && cmd.active_clear, "arm and stop")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the output pattern sequencer: directed table, then random beats
module tb;
   import ops_pkg::*;

   localparam int DEPTH      = 64;
   localparam int IDLE_LIMIT = 3000;
   localparam int RAND_BEATS = 1720;
   localparam int TAIL       = 2 * DEPTH + 16;

   localparam logic [OP_W-1:0]   OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0]   OP_SPARE_HI = 3'd7;
   localparam logic [CHAR_W-1:0] CH_BOGUS    = 8'h78;
   localparam logic [CHAR_W-1:0] CH_ALL_ONES = 8'hFF;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              level;
      logic [ADDR_W-1:0] address;
      logic [CHAR_W-1:0] char_code;
      logic [REF_W-1:0]  reference_ticks;
      logic              repeat_flag;
      logic              typed;
      logic              pin_level;
      logic              running;
   } beat_type;

   typedef struct packed {
      logic pin_level;
      logic running;
   } pin_status_type;

   logic clock;
   logic reset;

   ops_req_if req_bus ();
   ops_rsp_if rsp_bus ();

   output_pattern_sequencer_top #(
      .PATTERN_DEPTH (DEPTH),
      .TICK_WIDTH    (16)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor state
   logic [CHAR_W-1:0]  pattern_copy [DEPTH];
   logic [ADDR_W:0]    scan_ptr;
   logic [ADDR_W-1:0]  home_ptr;
   logic [SHIFT_W-1:0] shift_now;
   logic [REF_W-1:0]   ticks_left;
   logic [REF_W-1:0]   period_now;
   logic               pin_now;
   logic               timing;
   logic               looping;

   pin_status_type pin_status_due [$];
   int             errors;
   int             idle_cycles;
   bit             quiet_phase;

   beat_type directed_beats [27] = '{
      '{OP_TICK,     1'b0, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b1, 1'b0, 1'b0},
      '{OP_SET,      1'b1, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b1, 1'b1, 1'b0},
      '{OP_SET,      1'b0, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b1, 1'b0, 1'b0},
      '{OP_TOGGLE,   1'b0, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b1, 1'b1, 1'b0},
      '{OP_LOAD,     1'b0, 6'd0,  CH_PLUS,          16'd0,     1'b0, 1'b1, 1'b1, 1'b0},
      '{OP_LOAD,     1'b0, 6'd1,  CH_ZERO + 8'd2,   16'd0,     1'b0, 1'b1, 1'b1, 1'b0},
      '{OP_LOAD,     1'b0, 6'd2,  CH_SPACE,         16'd0,     1'b0, 1'b1, 1'b1, 1'b0},
      '{OP_LOAD,     1'b0, 6'd3,  CH_MINUS,         16'd0,     1'b0, 1'b1, 1'b1, 1'b0},
      '{OP_LOAD,     1'b0, 6'd4,  CH_NUL,           16'd0,     1'b0, 1'b1, 1'b1, 1'b0},
      '{OP_START,    1'b0, 6'd0,  CH_NUL,           16'd8,     1'b0, 1'b1, 1'b1, 1'b1},
      '{OP_TICK,     1'b0, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b1, 1'b1, 1'b1},
      // level mark right before the terminator still moves the pin
      '{OP_TICK,     1'b0, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b1, 1'b0, 1'b0},
      '{OP_TICK,     1'b0, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b1, 1'b0, 1'b0},
      '{OP_START,    1'b0, 6'd0,  CH_NUL,           16'd8,     1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_TICK,     1'b0, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_TICK,     1'b0, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b0, 1'b0, 1'b0},
      // interval of zero ticks
      '{OP_START,    1'b0, 6'd0,  CH_NUL,           16'd1,     1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_TICK,     1'b0, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b0, 1'b0, 1'b0},
      // unrecognized character stalls the pattern, shift carries over
      '{OP_LOAD,     1'b0, 6'd5,  CH_BOGUS,         16'd0,     1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_START,    1'b0, 6'd5,  CH_NUL,           16'd12,    1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_TICK,     1'b0, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_SPARE_LO, 1'b1, 6'd63, CH_ALL_ONES,      16'hFFFF,  1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_SPARE_HI, 1'b1, 6'd63, CH_ALL_ONES,      16'hFFFF,  1'b1, 1'b0, 1'b0, 1'b0},
      '{OP_LOAD,     1'b0, 6'd62, CH_MINUS,         16'd0,     1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_LOAD,     1'b0, 6'd63, CH_NINE,          16'd0,     1'b0, 1'b0, 1'b0, 1'b0},
      '{OP_START,    1'b0, 6'd62, CH_NUL,           16'hFFFF,  1'b0, 1'b1, 1'b0, 1'b1},
      '{OP_TOGGLE,   1'b0, 6'd0,  CH_NUL,           16'd0,     1'b0, 1'b1, 1'b1, 1'b0}
   };

   function automatic logic [CHAR_W-1:0] stored_char(input int unsigned p, output bit at_end);
      if (p >= DEPTH) begin
         at_end = 1'b1;
         return CH_NUL;
      end
      at_end = (pattern_copy[p] == CH_NUL);
      return pattern_copy[p];
   endfunction

   // one token; returns 0 when the pattern ran into its end and rewound
   function automatic bit take_token();
      int unsigned       p;
      bit                at_end;
      logic [CHAR_W-1:0] c;
      p = scan_ptr;
      c = stored_char(p, at_end);
      while (!at_end && c == CH_SPACE) begin
         p++;
         c = stored_char(p, at_end);
      end
      if (at_end) begin
         scan_ptr = {1'b0, home_ptr};
         return 1'b0;
      end
      if (c == CH_PLUS) begin
         pin_now = 1'b1;
         p++;
      end else if (c == CH_MINUS) begin
         pin_now = 1'b0;
         p++;
      end
      c = stored_char(p, at_end);
      if (at_end) begin
         scan_ptr = {1'b0, home_ptr};
         return 1'b0;
      end
      if (c >= CH_ZERO && c <= CH_NINE) begin
         shift_now = SHIFT_W'(c - CH_ZERO);
         p++;
      end
      scan_ptr = (ADDR_W + 1)'(p);
      return 1'b1;
   endfunction

   function automatic void next_interval();
      bit more;
      more = take_token();
      if (more || looping) begin
         ticks_left = period_now >> shift_now;
         timing = 1'b1;
      end else begin
         timing = 1'b0;
      end
   endfunction

   function automatic pin_status_type predict_pin_status(input beat_type b);
      pin_status_type s;
      case (b.op)
         OP_TICK: begin
            if (timing) begin
               if (ticks_left <= 1) begin
                  ticks_left = '0;
                  next_interval();
               end else begin
                  ticks_left = ticks_left - 1'b1;
               end
            end
         end
         OP_START: begin
            timing = 1'b0;
            home_ptr = b.address;
            scan_ptr = {1'b0, b.address};
            looping = b.repeat_flag;
            period_now = b.reference_ticks;
            next_interval();
         end
         OP_SET: begin
            timing = 1'b0;
            pin_now = b.level;
         end
         OP_TOGGLE: begin
            timing = 1'b0;
            pin_now = ~pin_now;
         end
         OP_LOAD: pattern_copy[b.address] = b.char_code;
         default: ;
      endcase
      s.pin_level = pin_now;
      s.running = timing;
      return s;
   endfunction

   // mostly no gap, some short ones, a few long
   function automatic int pick_gap();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [CHAR_W-1:0] pattern_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return CH_SPACE;
      if (r < 40) return CH_PLUS;
      if (r < 60) return CH_MINUS;
      if (r < 85) return CH_ZERO + CHAR_W'($urandom_range(0, 9));
      if (r < 93) return CH_NUL;
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic beat_type random_beat();
      beat_type b;
      int       r;
      b.level = 1'($urandom_range(0, 1));
      b.address = ADDR_W'($urandom_range(0, DEPTH - 1));
      b.char_code = CHAR_W'($urandom_range(0, 255));
      b.reference_ticks = REF_W'($urandom_range(0, 65535));
      b.repeat_flag = 1'($urandom_range(0, 1));
      b.typed = 1'b0;
      b.pin_level = 1'b0;
      b.running = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         b.op = OP_TICK;
      end else if (r < 75) begin
         b.op = OP_START;
         if ($urandom_range(0, 99) < 80) b.reference_ticks = REF_W'($urandom_range(0, 48));
      end else if (r < 90) begin
         b.op = OP_LOAD;
         b.char_code = pattern_char();
      end else if (r < 95) begin
         b.op = OP_SET;
      end else begin
         b.op = OP_TOGGLE;
      end
      return b;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_beat(input beat_type b);
      int             gap;
      pin_status_type s;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.op = b.op;
      req_bus.level = b.level;
      req_bus.address = b.address;
      req_bus.char_code = b.char_code;
      req_bus.reference_ticks = b.reference_ticks;
      req_bus.repeat_flag = b.repeat_flag;
      do @(posedge clock); while (!req_bus.ready);
      s = predict_pin_status(b);
      if (b.typed) begin
         s.pin_level = b.pin_level;
         s.running = b.running;
      end
      pin_status_due.push_back(s);
      @(negedge clock);
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         int stall;
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      pin_status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pin_status_due.size() == 0) begin
            $display("%0t unexpected response beat: pin_level %0b running %0b",
               $time, rsp_bus.pin_level, rsp_bus.running);
            errors++;
         end else begin
            want = pin_status_due.pop_front();
            if (rsp_bus.pin_level !== want.pin_level) begin
               $display("%0t pin_level expected %0b actual %0b",
                  $time, want.pin_level, rsp_bus.pin_level);
               errors++;
            end
            if (rsp_bus.running !== want.running) begin
               $display("%0t running expected %0b actual %0b",
                  $time, want.running, rsp_bus.running);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles", $time, IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      errors = 0;
      idle_cycles = 0;
      quiet_phase = 1'b0;
      scan_ptr = '0;
      home_ptr = '0;
      shift_now = '0;
      ticks_left = '0;
      period_now = '0;
      pin_now = 1'b0;
      timing = 1'b0;
      looping = 1'b0;
      for (int i = 0; i < DEPTH; i++) pattern_copy[i] = CH_NUL;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_TICK;
      req_bus.level = 1'b0;
      req_bus.address = '0;
      req_bus.char_code = '0;
      req_bus.reference_ticks = '0;
      req_bus.repeat_flag = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_beats[i]) send_beat(directed_beats[i]);

      // program every store entry before random starts can read it
      for (int a = 0; a < DEPTH; a++) begin
         beat_type b;
         b = random_beat();
         b.op = OP_LOAD;
         b.address = ADDR_W'(a);
         b.char_code = pattern_char();
         send_beat(b);
      end

      for (int n = 0; n < RAND_BEATS; n++) begin
         quiet_phase = ((n / 150) % 4) == 3;
         if (n == RAND_BEATS / 2) begin
            req_bus.valid = 1'b0;
            while (pin_status_due.size() != 0) @(negedge clock);
         end
         send_beat(random_beat());
      end
      req_bus.valid = 1'b0;

      while (pin_status_due.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
